// File: rtl/core/assert_macros.svh
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg)
`endif
`endif

// File: rtl/core/rtch_pkg.sv
package rtch_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_ORG_X   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ORG_Y   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ORG_Z   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DIR_X   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DIR_Y   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DIR_Z   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_T_LIMIT = 3'd6;

  localparam logic [1:0] DROP_X = 2'd0;
  localparam logic [1:0] DROP_Y = 2'd1;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] plane_dist;
    logic [1:0]         drop_axis;
    logic [63:0]        vert0_uv;
    logic [63:0]        vert1_uv;
    logic [63:0]        vert2_uv;
    logic [31:0]        tri_index;
    logic               degenerate;
    logic               last_tri;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_index;
    logic [30:0] hit_t;
    logic [16:0] hit_alpha;
    logic [16:0] hit_beta;
    logic        back_facing;
  } out_item_t;

  typedef enum logic [3:0] {
    MS_NONE, MS_DX, MS_DY, MS_DZ, MS_OX, MS_OY, MS_OZ, MS_P0, MS_P1,
    MS_V0U1, MS_U0V1, MS_V2U1, MS_U2V1, MS_BU2
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_e;

  typedef enum logic [3:0] {
    SV_NONE, SV_VDOT, SV_VDOT2, SV_T, SV_P0, SV_P1, SV_DIFF, SV_BN, SV_BD,
    SV_BETA, SV_AN, SV_BEST
  } save_e;

  typedef enum logic [1:0] {
    DIV_T, DIV_B, DIV_A
  } div_sel_e;

  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    save_e    save;
    logic     div_start;
    div_sel_e div_sel;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic degenerate;
    logic last;
    logic vdot_zero;
    logic t_reject;
    logic bd_zero;
    logic beta_reject;
    logic alpha_reject;
    logic out_full;
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_M_DX, ST_M_DY, ST_M_DZ, ST_M_OX, ST_M_OY, ST_M_OZ, ST_ACC_O,
    ST_VD2, ST_DIV_T, ST_WAIT_T, ST_M_P0, ST_M_P1, ST_SV_P1, ST_DIFF, ST_M_A,
    ST_M_B, ST_M_C, ST_M_D, ST_BD_ACC, ST_BD_SV, ST_DIV_B, ST_WAIT_B,
    ST_M_BU2, ST_AN, ST_DIV_A, ST_WAIT_A, ST_DONE
  } ctrl_state_e;

endpackage

// File: rtl/core/rtch_div.sv
module rtch_div #(
  parameter int unsigned NumW = 50
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic signed [31:0]     den_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic signed [NumW:0]   quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [31:0]     rem_q, den_q;
  logic [NumW-1:0] quo_q;
  logic            neg_q;

  logic [NumW-1:0] num_u, num_mag;
  logic [31:0]     den_u, den_mag;
  logic [33:0]     trial;

  assign num_u   = num_i;
  assign den_u   = den_i;
  assign num_mag = num_u[NumW-1] ? (~num_u + NumW'(1)) : num_u;
  assign den_mag = den_u[31] ? (~den_u + 32'd1) : den_u;
  // shift in next dividend bit and try the subtract
  assign trial   = {1'b0, rem_q, quo_q[NumW-1]} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(NumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_mag;
      den_q <= den_mag;
      neg_q <= num_u[NumW-1] ^ den_u[31];
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[NumW-1]};
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// File: rtl/core/rtch_datapath.sv
module rtch_datapath #(
  parameter int unsigned FracBits = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rtch_pkg::cmd_t                    cmd_i,
  output rtch_pkg::status_t                 st_o,
  input  rtch_pkg::in_item_t                in_item_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output rtch_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [rtch_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [31:0]                       cfg_wdata_i
);

  localparam int unsigned NumW   = 34 + FracBits;
  localparam int unsigned EpsInt = ((1 << FracBits) + 50) / 100;
  localparam logic signed [NumW:0] EpsQ  = (NumW+1)'(EpsInt);
  localparam logic signed [NumW:0] OneQ  = {{(NumW-FracBits){1'b0}}, 1'b1,
                                            {FracBits{1'b0}}};
  localparam logic [30:0]          TMax  = '1;
  localparam logic signed [NumW:0] TMaxQ = {{(NumW-30){1'b0}}, TMax};
  localparam logic signed [65:0]   SatHi = 66'sd2147483647;
  localparam logic signed [65:0]   SatLo = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > SatHi) r = 32'sh7FFFFFFF;
    else if (x < SatLo) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // configuration and running state
  logic signed [31:0] org_q [3];
  logic signed [31:0] dir_q [3];
  logic [30:0]        t_limit_q, best_t_q;
  logic               found_q, out_valid_q;

  rtch_pkg::in_item_t  item_q;
  rtch_pkg::out_item_t out_q;

  logic signed [63:0] prod_q, prod_sh;
  logic signed [65:0] acc_q;
  logic signed [31:0] vdot_q, vdot2_q, p0_q, p1_q;
  logic signed [31:0] u0_q, v0_q, u1_q, v1_q, u2_q, v2_q, bn_q, bd_q;
  logic signed [33:0] an_q;
  logic [30:0]        t_q;
  logic [FracBits:0]  beta_q, best_alpha_q, best_beta_q;
  logic [31:0]        best_index_q;
  logic               best_facing_q;

  logic signed [31:0] org1, org2, dir1, dir2, mul_a, mul_b;
  logic signed [31:0] a0u, a0v, a1u, a1v, a2u, a2v;
  logic signed [32:0] dt;
  logic signed [NumW-1:0] div_num;
  logic signed [31:0]     div_den;
  logic signed [NumW:0]   div_q, t_lim, beta_ext;
  logic                   div_busy, div_done;

  always_comb begin
    case (item_q.drop_axis)
      rtch_pkg::DROP_X: begin
        org1 = org_q[1]; dir1 = dir_q[1]; org2 = org_q[2]; dir2 = dir_q[2];
      end
      rtch_pkg::DROP_Y: begin
        org1 = org_q[0]; dir1 = dir_q[0]; org2 = org_q[2]; dir2 = dir_q[2];
      end
      default: begin
        org1 = org_q[0]; dir1 = dir_q[0]; org2 = org_q[1]; dir2 = dir_q[1];
      end
    endcase
  end

  assign a0u = $signed(item_q.vert0_uv[63:32]);
  assign a0v = $signed(item_q.vert0_uv[31:0]);
  assign a1u = $signed(item_q.vert1_uv[63:32]);
  assign a1v = $signed(item_q.vert1_uv[31:0]);
  assign a2u = $signed(item_q.vert2_uv[63:32]);
  assign a2v = $signed(item_q.vert2_uv[31:0]);

  always_comb begin
    case (cmd_i.mul_sel)
      rtch_pkg::MS_DX:   begin mul_a = dir_q[0]; mul_b = item_q.normal_x; end
      rtch_pkg::MS_DY:   begin mul_a = dir_q[1]; mul_b = item_q.normal_y; end
      rtch_pkg::MS_DZ:   begin mul_a = dir_q[2]; mul_b = item_q.normal_z; end
      rtch_pkg::MS_OX:   begin mul_a = org_q[0]; mul_b = item_q.normal_x; end
      rtch_pkg::MS_OY:   begin mul_a = org_q[1]; mul_b = item_q.normal_y; end
      rtch_pkg::MS_OZ:   begin mul_a = org_q[2]; mul_b = item_q.normal_z; end
      rtch_pkg::MS_P0:   begin mul_a = dir1; mul_b = $signed({1'b0, t_q}); end
      rtch_pkg::MS_P1:   begin mul_a = dir2; mul_b = $signed({1'b0, t_q}); end
      rtch_pkg::MS_V0U1: begin mul_a = v0_q; mul_b = u1_q; end
      rtch_pkg::MS_U0V1: begin mul_a = u0_q; mul_b = v1_q; end
      rtch_pkg::MS_V2U1: begin mul_a = v2_q; mul_b = u1_q; end
      rtch_pkg::MS_U2V1: begin mul_a = u2_q; mul_b = v1_q; end
      rtch_pkg::MS_BU2:  begin mul_a = $signed(32'(beta_q)); mul_b = u2_q; end
      default:           begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // floor of the fixed point product
  assign prod_sh = prod_q >>> FracBits;

  assign dt = 33'(item_q.plane_dist) - 33'(vdot2_q);

  always_comb begin
    case (cmd_i.div_sel)
      rtch_pkg::DIV_T: begin div_num = NumW'(dt) <<< FracBits;   div_den = vdot_q; end
      rtch_pkg::DIV_B: begin div_num = NumW'(bn_q) <<< FracBits; div_den = bd_q; end
      default:         begin div_num = NumW'(an_q) <<< FracBits; div_den = u1_q; end
    endcase
  end

  rtch_div #(.NumW(NumW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  assign t_lim    = $signed((NumW+1)'(best_t_q)) + EpsQ;
  assign beta_ext = $signed((NumW+1)'(beta_q));

  always_comb begin
    st_o.div_busy     = div_busy;
    st_o.div_done     = div_done;
    st_o.degenerate   = item_q.degenerate;
    st_o.last         = item_q.last_tri;
    st_o.vdot_zero    = (vdot_q == 32'sd0);
    st_o.t_reject     = (div_q < EpsQ) || (div_q > t_lim);
    st_o.bd_zero      = (bd_q == 32'sd0);
    st_o.beta_reject  = (div_q < 0) || (div_q > OneQ) || (u1_q == 32'sd0);
    st_o.alpha_reject = (div_q < 0) || ((div_q + beta_ext) > OneQ);
    st_o.out_full     = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= '0;
        dir_q[i] <= '0;
      end
      t_limit_q   <= TMax;
      best_t_q    <= TMax;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.save == rtch_pkg::SV_BEST) begin
        best_t_q <= t_q;
        found_q  <= 1'b1;
      end
      if (cmd_i.emit) begin
        best_t_q    <= t_limit_q;
        found_q     <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rtch_pkg::REG_ORG_X: org_q[0] <= cfg_wdata_i;
          rtch_pkg::REG_ORG_Y: org_q[1] <= cfg_wdata_i;
          rtch_pkg::REG_ORG_Z: org_q[2] <= cfg_wdata_i;
          rtch_pkg::REG_DIR_X: dir_q[0] <= cfg_wdata_i;
          rtch_pkg::REG_DIR_Y: dir_q[1] <= cfg_wdata_i;
          rtch_pkg::REG_DIR_Z: dir_q[2] <= cfg_wdata_i;
          rtch_pkg::REG_T_LIMIT: begin
            t_limit_q <= cfg_wdata_i[30:0];
            if (!found_q) best_t_q <= cfg_wdata_i[30:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
    prod_q <= mul_a * mul_b;
    case (cmd_i.acc_op)
      rtch_pkg::ACC_LOAD: acc_q <= 66'(prod_sh);
      rtch_pkg::ACC_ADD:  acc_q <= acc_q + 66'(prod_sh);
      rtch_pkg::ACC_SUB:  acc_q <= acc_q - 66'(prod_sh);
      default: ;
    endcase
    case (cmd_i.save)
      rtch_pkg::SV_VDOT:  vdot_q  <= sat32(acc_q);
      rtch_pkg::SV_VDOT2: vdot2_q <= sat32(acc_q);
      rtch_pkg::SV_T:     t_q     <= (div_q > TMaxQ) ? TMax : div_q[30:0];
      rtch_pkg::SV_P0:    p0_q    <= sat32(66'(org1) + 66'(prod_sh));
      rtch_pkg::SV_P1:    p1_q    <= sat32(66'(org2) + 66'(prod_sh));
      rtch_pkg::SV_DIFF: begin
        u0_q <= sat32(66'(p0_q) - 66'(a0u));
        v0_q <= sat32(66'(p1_q) - 66'(a0v));
        u1_q <= sat32(66'(a1u) - 66'(a0u));
        v1_q <= sat32(66'(a1v) - 66'(a0v));
        u2_q <= sat32(66'(a2u) - 66'(a0u));
        v2_q <= sat32(66'(a2v) - 66'(a0v));
      end
      rtch_pkg::SV_BN:    bn_q   <= sat32(acc_q);
      rtch_pkg::SV_BD:    bd_q   <= sat32(acc_q);
      rtch_pkg::SV_BETA:  beta_q <= div_q[FracBits:0];
      rtch_pkg::SV_AN:    an_q   <= 34'(66'(u0_q) - 66'(prod_sh));
      rtch_pkg::SV_BEST: begin
        best_alpha_q  <= div_q[FracBits:0];
        best_beta_q   <= beta_q;
        best_index_q  <= item_q.tri_index;
        best_facing_q <= (vdot_q > 32'sd0);
      end
      default: ;
    endcase
    if (cmd_i.emit) begin
      out_q.hit         <= found_q;
      out_q.hit_index   <= found_q ? best_index_q : '0;
      out_q.hit_t       <= found_q ? best_t_q : '0;
      out_q.hit_alpha   <= found_q ? 17'(best_alpha_q) : '0;
      out_q.hit_beta    <= found_q ? 17'(best_beta_q) : '0;
      out_q.back_facing <= found_q && best_facing_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/core/rtch_ctrl.sv
`include "assert_macros.svh"

module rtch_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rtch_pkg::status_t st_i,
  output rtch_pkg::cmd_t    cmd_o
);

  rtch_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rtch_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rtch_pkg::ST_IDLE:   if (in_valid_i) state_d = rtch_pkg::ST_M_DX;
      rtch_pkg::ST_M_DX:   state_d = st_i.degenerate ? rtch_pkg::ST_DONE : rtch_pkg::ST_M_DY;
      rtch_pkg::ST_M_DY:   state_d = rtch_pkg::ST_M_DZ;
      rtch_pkg::ST_M_DZ:   state_d = rtch_pkg::ST_M_OX;
      rtch_pkg::ST_M_OX:   state_d = rtch_pkg::ST_M_OY;
      rtch_pkg::ST_M_OY:   state_d = rtch_pkg::ST_M_OZ;
      rtch_pkg::ST_M_OZ:   state_d = rtch_pkg::ST_ACC_O;
      rtch_pkg::ST_ACC_O:  state_d = rtch_pkg::ST_VD2;
      rtch_pkg::ST_VD2:    state_d = st_i.vdot_zero ? rtch_pkg::ST_DONE : rtch_pkg::ST_DIV_T;
      rtch_pkg::ST_DIV_T:  state_d = rtch_pkg::ST_WAIT_T;
      rtch_pkg::ST_WAIT_T: begin
        if (st_i.div_done) begin
          state_d = st_i.t_reject ? rtch_pkg::ST_DONE : rtch_pkg::ST_M_P0;
        end
      end
      rtch_pkg::ST_M_P0:   state_d = rtch_pkg::ST_M_P1;
      rtch_pkg::ST_M_P1:   state_d = rtch_pkg::ST_SV_P1;
      rtch_pkg::ST_SV_P1:  state_d = rtch_pkg::ST_DIFF;
      rtch_pkg::ST_DIFF:   state_d = rtch_pkg::ST_M_A;
      rtch_pkg::ST_M_A:    state_d = rtch_pkg::ST_M_B;
      rtch_pkg::ST_M_B:    state_d = rtch_pkg::ST_M_C;
      rtch_pkg::ST_M_C:    state_d = rtch_pkg::ST_M_D;
      rtch_pkg::ST_M_D:    state_d = rtch_pkg::ST_BD_ACC;
      rtch_pkg::ST_BD_ACC: state_d = rtch_pkg::ST_BD_SV;
      rtch_pkg::ST_BD_SV:  state_d = rtch_pkg::ST_DIV_B;
      rtch_pkg::ST_DIV_B:  state_d = st_i.bd_zero ? rtch_pkg::ST_DONE : rtch_pkg::ST_WAIT_B;
      rtch_pkg::ST_WAIT_B: begin
        if (st_i.div_done) begin
          state_d = st_i.beta_reject ? rtch_pkg::ST_DONE : rtch_pkg::ST_M_BU2;
        end
      end
      rtch_pkg::ST_M_BU2:  state_d = rtch_pkg::ST_AN;
      rtch_pkg::ST_AN:     state_d = rtch_pkg::ST_DIV_A;
      rtch_pkg::ST_DIV_A:  state_d = rtch_pkg::ST_WAIT_A;
      rtch_pkg::ST_WAIT_A: if (st_i.div_done) state_d = rtch_pkg::ST_DONE;
      rtch_pkg::ST_DONE: begin
        if (!st_i.last || !st_i.out_full) state_d = rtch_pkg::ST_IDLE;
      end
      default:             state_d = rtch_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.mul_sel   = rtch_pkg::MS_NONE;
    cmd_o.acc_op    = rtch_pkg::ACC_NONE;
    cmd_o.save      = rtch_pkg::SV_NONE;
    cmd_o.div_start = 1'b0;
    cmd_o.div_sel   = rtch_pkg::DIV_T;
    cmd_o.emit      = 1'b0;
    case (state_q)
      rtch_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rtch_pkg::ST_M_DX: cmd_o.mul_sel = rtch_pkg::MS_DX;
      rtch_pkg::ST_M_DY: begin
        cmd_o.mul_sel = rtch_pkg::MS_DY;
        cmd_o.acc_op  = rtch_pkg::ACC_LOAD;
      end
      rtch_pkg::ST_M_DZ: begin
        cmd_o.mul_sel = rtch_pkg::MS_DZ;
        cmd_o.acc_op  = rtch_pkg::ACC_ADD;
      end
      rtch_pkg::ST_M_OX: begin
        cmd_o.mul_sel = rtch_pkg::MS_OX;
        cmd_o.acc_op  = rtch_pkg::ACC_ADD;
      end
      rtch_pkg::ST_M_OY: begin
        cmd_o.mul_sel = rtch_pkg::MS_OY;
        cmd_o.acc_op  = rtch_pkg::ACC_LOAD;
        cmd_o.save    = rtch_pkg::SV_VDOT;
      end
      rtch_pkg::ST_M_OZ: begin
        cmd_o.mul_sel = rtch_pkg::MS_OZ;
        cmd_o.acc_op  = rtch_pkg::ACC_ADD;
      end
      rtch_pkg::ST_ACC_O: cmd_o.acc_op = rtch_pkg::ACC_ADD;
      rtch_pkg::ST_VD2:   cmd_o.save = rtch_pkg::SV_VDOT2;
      rtch_pkg::ST_DIV_T: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = rtch_pkg::DIV_T;
      end
      rtch_pkg::ST_WAIT_T: begin
        if (st_i.div_done && !st_i.t_reject) cmd_o.save = rtch_pkg::SV_T;
      end
      rtch_pkg::ST_M_P0: cmd_o.mul_sel = rtch_pkg::MS_P0;
      rtch_pkg::ST_M_P1: begin
        cmd_o.mul_sel = rtch_pkg::MS_P1;
        cmd_o.save    = rtch_pkg::SV_P0;
      end
      rtch_pkg::ST_SV_P1: cmd_o.save = rtch_pkg::SV_P1;
      rtch_pkg::ST_DIFF:  cmd_o.save = rtch_pkg::SV_DIFF;
      rtch_pkg::ST_M_A:   cmd_o.mul_sel = rtch_pkg::MS_V0U1;
      rtch_pkg::ST_M_B: begin
        cmd_o.mul_sel = rtch_pkg::MS_U0V1;
        cmd_o.acc_op  = rtch_pkg::ACC_LOAD;
      end
      rtch_pkg::ST_M_C: begin
        cmd_o.mul_sel = rtch_pkg::MS_V2U1;
        cmd_o.acc_op  = rtch_pkg::ACC_SUB;
      end
      rtch_pkg::ST_M_D: begin
        cmd_o.mul_sel = rtch_pkg::MS_U2V1;
        cmd_o.acc_op  = rtch_pkg::ACC_LOAD;
        cmd_o.save    = rtch_pkg::SV_BN;
      end
      rtch_pkg::ST_BD_ACC: cmd_o.acc_op = rtch_pkg::ACC_SUB;
      rtch_pkg::ST_BD_SV:  cmd_o.save = rtch_pkg::SV_BD;
      rtch_pkg::ST_DIV_B: begin
        cmd_o.div_start = !st_i.bd_zero;
        cmd_o.div_sel   = rtch_pkg::DIV_B;
      end
      rtch_pkg::ST_WAIT_B: begin
        cmd_o.div_sel = rtch_pkg::DIV_B;
        if (st_i.div_done && !st_i.beta_reject) cmd_o.save = rtch_pkg::SV_BETA;
      end
      rtch_pkg::ST_M_BU2: cmd_o.mul_sel = rtch_pkg::MS_BU2;
      rtch_pkg::ST_AN:    cmd_o.save = rtch_pkg::SV_AN;
      rtch_pkg::ST_DIV_A: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = rtch_pkg::DIV_A;
      end
      rtch_pkg::ST_WAIT_A: begin
        cmd_o.div_sel = rtch_pkg::DIV_A;
        if (st_i.div_done && !st_i.alpha_reject) cmd_o.save = rtch_pkg::SV_BEST;
      end
      rtch_pkg::ST_DONE: cmd_o.emit = st_i.last && !st_i.out_full;
      default: ;
    endcase
  end

  `ASSERT_IMPLIES(a_emit_last, clk_i, rst_ni, cmd_o.emit, st_i.last && !st_i.out_full, "emit without a free last beat")
  `ASSERT_IMPLIES(a_div_free, clk_i, rst_ni, cmd_o.div_start, !st_i.div_busy, "divider restarted while busy")
  `ASSERT_NEXT(a_div_runs, clk_i, rst_ni, cmd_o.div_start, st_i.div_busy, "divider did not start")
  `ASSERT_IMPLIES(a_best_on_done, clk_i, rst_ni, cmd_o.save == rtch_pkg::SV_BEST, st_i.div_done, "best updated without a quotient")

endmodule

// File: rtl/core/ray_triangle_closest_hit_top.sv
// closest-hit test of one ray against the triangles of a leaf
// config: write cfg_we_i with cfg_idx_i 0..6 (origin xyz, direction xyz,
//   t limit) while the block is idle; writes take effect at once
// input: one beat per triangle on in_valid_i / in_ready_o; a beat with
//   last_tri set closes the leaf
// output: one beat per leaf on out_valid_o / out_ready_i with the closest
//   hit (or hit = 0 and all zero fields), then the search restarts
// one triangle at a time: the next input beat is taken only once the current
//   test ends; the length of a full test is set by the three radix-2 divisions
//   of t, beta and alpha on one shared one-bit-per-cycle divider (values in
//   Q16.16 at the default FRAC_BITS); a degenerate triangle, a parallel one, a
//   rejected distance, a zero beta divisor or a rejected beta ends it early
// the result beat is registered as the last triangle leaves the test and
//   sits in an output register, so the next leaf is taken while it waits;
//   only the last triangle of a following leaf stalls until the receiver
//   has taken the pending result
// reset: ray registers go to zero, t limit to its maximum, no hit pending
module ray_triangle_closest_hit_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rtch_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rtch_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [rtch_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i
);

  rtch_pkg::cmd_t    cmd;
  rtch_pkg::status_t st;

  rtch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  rtch_datapath #(.FracBits(FRAC_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned FRAC = 16;
  localparam logic [rtch_pkg::CfgIdxW-1:0] REG_SPARE = 3'd7;
  localparam longint ONE_Q = 64'sd1 <<< FRAC;
  localparam longint EPS_Q = (ONE_Q + 50) / 100;
  localparam longint T_MAX = 64'sd2147483647;
  localparam int DRAIN_CYCLES = 250;

  class closest_hit_scoreboard;
    longint org[3], dir[3], t_lim;
    longint best_t, best_a, best_b;
    logic [31:0] best_idx;
    bit found, facing;
    rtch_pkg::out_item_t pending[$];
    int errors, n_leaf, n_hit, n_tri;

    function new();
      foreach (org[i]) begin
        org[i] = 0;
        dir[i] = 0;
      end
      t_lim = T_MAX;
      errors = 0;
      n_leaf = 0;
      n_hit = 0;
      n_tri = 0;
      restart();
    endfunction

    function void restart();
      best_t = t_lim;
      best_a = 0;
      best_b = 0;
      best_idx = '0;
      found = 0;
      facing = 0;
    endfunction

    function longint sat(longint x);
      if (x > T_MAX) return T_MAX;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // fixed-point product, floor of the exact result
    function longint mulq(longint a, longint b);
      return (a * b) >>> FRAC;
    endfunction

    function longint s32(logic [31:0] v);
      return longint'($signed(v));
    endfunction

    function void write_reg(logic [rtch_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
      case (idx)
        rtch_pkg::REG_ORG_X: org[0] = s32(val);
        rtch_pkg::REG_ORG_Y: org[1] = s32(val);
        rtch_pkg::REG_ORG_Z: org[2] = s32(val);
        rtch_pkg::REG_DIR_X: dir[0] = s32(val);
        rtch_pkg::REG_DIR_Y: dir[1] = s32(val);
        rtch_pkg::REG_DIR_Z: dir[2] = s32(val);
        rtch_pkg::REG_T_LIMIT: begin
          t_lim = longint'(val[30:0]);
          if (!found) best_t = t_lim;
        end
        default: ;
      endcase
    endfunction

    function void test_tri(rtch_pkg::in_item_t it);
      longint n[3];
      longint d, vdot, vdot2, t, p0, p1, a0u, a0v, u0, v0, u1, v1, u2, v2;
      longint bn, bd, beta, an, alpha;
      int i1, i2;
      n[0] = s32(it.normal_x);
      n[1] = s32(it.normal_y);
      n[2] = s32(it.normal_z);
      d = s32(it.plane_dist);
      vdot = sat(mulq(dir[0], n[0]) + mulq(dir[1], n[1]) + mulq(dir[2], n[2]));
      if (vdot == 0) return;
      vdot2 = sat(mulq(org[0], n[0]) + mulq(org[1], n[1]) + mulq(org[2], n[2]));
      t = ((d - vdot2) * ONE_Q) / vdot;
      if (t < EPS_Q || t > best_t + EPS_Q) return;
      if (t > T_MAX) t = T_MAX;
      if (it.drop_axis == rtch_pkg::DROP_X) begin
        i1 = 1; i2 = 2;
      end else if (it.drop_axis == rtch_pkg::DROP_Y) begin
        i1 = 0; i2 = 2;
      end else begin
        i1 = 0; i2 = 1;
      end
      p0 = sat(org[i1] + mulq(dir[i1], t));
      p1 = sat(org[i2] + mulq(dir[i2], t));
      a0u = s32(it.vert0_uv[63:32]);
      a0v = s32(it.vert0_uv[31:0]);
      u0 = sat(p0 - a0u);
      v0 = sat(p1 - a0v);
      u1 = sat(s32(it.vert1_uv[63:32]) - a0u);
      v1 = sat(s32(it.vert1_uv[31:0]) - a0v);
      u2 = sat(s32(it.vert2_uv[63:32]) - a0u);
      v2 = sat(s32(it.vert2_uv[31:0]) - a0v);
      bn = sat(mulq(v0, u1) - mulq(u0, v1));
      bd = sat(mulq(v2, u1) - mulq(u2, v1));
      if (bd == 0) return;
      beta = (bn * ONE_Q) / bd;
      if (beta < 0 || beta > ONE_Q) return;
      if (u1 == 0) return;
      an = u0 - mulq(beta, u2);
      alpha = (an * ONE_Q) / u1;
      if (alpha < 0 || alpha + beta > ONE_Q) return;
      best_t = t;
      best_a = alpha;
      best_b = beta;
      best_idx = it.tri_index;
      found = 1;
      facing = vdot > 0;
    endfunction

    function void note_input(rtch_pkg::in_item_t it);
      rtch_pkg::out_item_t r;
      n_tri++;
      if (!it.degenerate) test_tri(it);
      if (!it.last_tri) return;
      r = '0;
      if (found) begin
        r.hit = 1'b1;
        r.hit_index = best_idx;
        r.hit_t = best_t[30:0];
        r.hit_alpha = best_a[16:0];
        r.hit_beta = best_b[16:0];
        r.back_facing = facing;
        n_hit++;
      end
      pending = {pending, r};
      restart();
    endfunction

    function void check(rtch_pkg::out_item_t got);
      rtch_pkg::out_item_t e;
      n_leaf++;
      if (pending.size() == 0) begin
        $error("unexpected result beat: %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) begin
        $error("hit expected %0h actual %0h", e.hit, got.hit); errors++;
      end
      if (got.hit_index !== e.hit_index) begin
        $error("hit_index expected %0h actual %0h", e.hit_index, got.hit_index); errors++;
      end
      if (got.hit_t !== e.hit_t) begin
        $error("hit_t expected %0h actual %0h", e.hit_t, got.hit_t); errors++;
      end
      if (got.hit_alpha !== e.hit_alpha) begin
        $error("hit_alpha expected %0h actual %0h", e.hit_alpha, got.hit_alpha); errors++;
      end
      if (got.hit_beta !== e.hit_beta) begin
        $error("hit_beta expected %0h actual %0h", e.hit_beta, got.hit_beta); errors++;
      end
      if (got.back_facing !== e.back_facing) begin
        $error("back_facing expected %0h actual %0h", e.back_facing, got.back_facing);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  rtch_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rtch_pkg::out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [rtch_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  closest_hit_scoreboard sb = new();
  bit no_idle = 0;
  bit hold_req = 0;
  int sent = 0;

  ray_triangle_closest_hit_top #(.FRAC_BITS(FRAC)) uut (.*);

  always #10 clk_i = ~clk_i;

  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_input(in_item_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check(out_item_o);
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        stall = 3000;
      end
      if (stall == 0 && !no_idle) stall = pick_gap();
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic send(input rtch_pkg::in_item_t it);
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_item_i = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [rtch_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, lim);
    cfg_write(rtch_pkg::REG_ORG_X, ox);
    cfg_write(rtch_pkg::REG_ORG_Y, oy);
    cfg_write(rtch_pkg::REG_ORG_Z, oz);
    cfg_write(rtch_pkg::REG_DIR_X, dx);
    cfg_write(rtch_pkg::REG_DIR_Y, dy);
    cfg_write(rtch_pkg::REG_DIR_Z, dz);
    cfg_write(rtch_pkg::REG_T_LIMIT, lim);
    cfg_write(REG_SPARE, $urandom);
  endtask

  function automatic rtch_pkg::in_item_t make_tri(int nx, ny, nz, pdist, logic [1:0] drop,
                                                  int ua, va, ub, vb, uc, vc,
                                                  logic [31:0] idx, bit deg, bit last);
    rtch_pkg::in_item_t it;
    it.normal_x = nx;
    it.normal_y = ny;
    it.normal_z = nz;
    it.plane_dist = pdist;
    it.drop_axis = drop;
    it.vert0_uv = {ua, va};
    it.vert1_uv = {ub, vb};
    it.vert2_uv = {uc, vc};
    it.tri_index = idx;
    it.degenerate = deg;
    it.last_tri = last;
    return it;
  endfunction

  function automatic int jitter(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // plane crossed by the current ray near a chosen distance, vertices around the hit
  function automatic rtch_pkg::in_item_t shaped_tri(bit last);
    rtch_pkg::in_item_t it;
    longint p[3], n[3], plane_off, tt;
    int k, i1, i2;
    logic [1:0] drop;
    drop = 2'($urandom_range(0, 3));
    k = (drop == 2'd3) ? 2 : int'(drop);
    foreach (n[i]) n[i] = longint'(jitter(9000));
    n[k] = longint'(($urandom_range(0, 1) ? 65536 : -65536) + jitter(3000));
    tt = longint'($urandom_range(32'h1000, 32'h40_0000));
    plane_off = 0;
    foreach (p[i]) begin
      p[i] = sb.org[i] + sb.mulq(sb.dir[i], tt);
      plane_off += sb.mulq(n[i], p[i]);
    end
    i1 = (k == 0) ? 1 : 0;
    i2 = (k == 2) ? 1 : 2;
    it = make_tri(int'(n[0]), int'(n[1]), int'(n[2]), int'(sb.sat(plane_off)), drop,
                  int'(p[i1] + jitter(32'h30000)), int'(p[i2] + jitter(32'h30000)),
                  int'(p[i1] + jitter(32'h40000)), int'(p[i2] + jitter(32'h40000)),
                  int'(p[i1] + jitter(32'h40000)), int'(p[i2] + jitter(32'h40000)),
                  $urandom, $urandom_range(0, 29) == 0, last);
    return it;
  endfunction

  function automatic rtch_pkg::in_item_t noise_tri();
    rtch_pkg::in_item_t it;
    it = make_tri($urandom, $urandom, $urandom, $urandom, 2'($urandom_range(0, 3)),
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    return it;
  endfunction

  task automatic random_leaf(input int max_len);
    int len;
    len = $urandom_range(1, max_len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) < 2 && i < len - 1) send(noise_tri());
      else send(shaped_tri(i == len - 1));
    end
  endtask

  initial begin
    int phase;
    logic [31:0] lim;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // ray along +z from the origin; plane z = c gives t = c
    set_ray(0, 0, 0, 0, 0, 32'h10000, 32'h7fff_ffff);
    send(make_tri(0, 0, 65536, 5 << 16, 2, -65536, -65536, 2 << 16, -65536,
                  -65536, 2 << 16, 1, 0, 0));
    send(make_tri(0, 0, 65536, 5 << 16, 2, -65536, -65536, 2 << 16, -65536,
                  -65536, 2 << 16, 2, 0, 1));
    // degenerate flag
    send(make_tri(0, 0, 65536, 5 << 16, 2, -65536, -65536, 2 << 16, -65536,
                  -65536, 2 << 16, 3, 1, 1));
    // ray parallel to the plane
    send(make_tri(65536, 0, 0, 5 << 16, 0, -65536, -65536, 2 << 16, -65536,
                  -65536, 2 << 16, 4, 0, 1));
    // plane through the origin, below epsilon
    send(make_tri(0, 0, 65536, 0, 2, -65536, -65536, 2 << 16, -65536,
                  -65536, 2 << 16, 5, 0, 1));
    // far, nearer, then farther than the best so far
    send(make_tri(0, 0, 65536, 10 << 16, 2, -65536, -65536, 2 << 16, -65536,
                  -65536, 2 << 16, 6, 0, 0));
    send(make_tri(0, 0, 65536, 5 << 16, 2, -65536, -65536, 2 << 16, -65536,
                  -65536, 2 << 16, 7, 0, 0));
    send(make_tri(0, 0, 65536, 20 << 16, 2, -65536, -65536, 2 << 16, -65536,
                  -65536, 2 << 16, 8, 0, 1));
    // zero u1
    send(make_tri(0, 0, 65536, 5 << 16, 2, -65536, -65536, -65536, 2 << 16,
                  2 << 16, 2 << 16, 9, 0, 1));
    // collinear vertices, zero beta divisor
    send(make_tri(0, 0, 65536, 5 << 16, 2, -65536, -65536, 65536, 65536,
                  2 << 16, 2 << 16, 10, 0, 1));
    // point outside the triangle
    send(make_tri(0, 0, 65536, 5 << 16, 2, 5 << 16, 5 << 16, 6 << 16, 5 << 16,
                  5 << 16, 6 << 16, 11, 0, 1));
    // drop axis three, and a flipped normal
    send(make_tri(0, 0, 65536, 3 << 16, 3, -65536, -65536, 2 << 16, -65536,
                  -65536, 2 << 16, 12, 0, 1));
    send(make_tri(0, 0, -65536, -(4 << 16), 2, -65536, -65536, 2 << 16, -65536,
                  -65536, 2 << 16, 13, 0, 1));
    // field extremes
    send(make_tri(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 3,
                  -1, -1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                  32'hffff_ffff, 0, 1));
    send(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    drain();

    // extreme ray and a zero limit
    set_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff, 0);
    for (int i = 0; i < 4; i++) random_leaf(3);
    drain();

    phase = 0;
    while (sent < 1100) begin
      lim = ($urandom_range(0, 3) == 0) ? 32'h7fff_ffff : $urandom_range(0, 32'h30_0000);
      set_ray(jitter(32'h10_0000), jitter(32'h10_0000), jitter(32'h10_0000),
              jitter(32'h20000), jitter(32'h20000), jitter(32'h20000), lim);
      no_idle = (phase % 4 == 3);
      if (phase == 2) begin
        hold_req = 1;
        for (int i = 0; i < 30; i++) send(shaped_tri(1));
      end
      for (int i = 0; i < 25; i++) random_leaf(6);
      no_idle = 0;
      drain();
      phase++;
    end

    $display("%0d triangles over %0d ray settings, %0d leaf results checked, %0d hits",
             sb.n_tri, phase + 2, sb.n_leaf, sb.n_hit);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
